@@ rtl/core/gwsd_pkg.sv @@
// Shared constants, types and state codes of the ground window safe detector.
package gwsd_pkg;

	localparam int MAP_CELLS  = 25;
	localparam int SEAT_CELLS = 9;

	localparam int POS_W    = 16;
	localparam int HEIGHT_W = 12;
	localparam int SUM_W    = HEIGHT_W + 1;
	localparam int IDX_W    = $clog2(MAP_CELLS);

	// A biased position is never negative and stays below two to the BIAS_W.
	localparam int BIAS_W      = 17;
	localparam int LOW_MARGIN  = 32768 + MAP_CELLS / 2 + SEAT_CELLS / 2;
	localparam int BIAS_OFFSET = MAP_CELLS * ((LOW_MARGIN + MAP_CELLS - 1) / MAP_CELLS);

	// The quotient is an exact floor for every biased position with this shift.
	localparam int CELLS_LOG = $clog2(MAP_CELLS);
	localparam int RECIP_SH  = BIAS_W + CELLS_LOG;
	localparam int RECIP_W   = BIAS_W + 1;
	localparam int QUO_W     = BIAS_W - CELLS_LOG + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((2 ** RECIP_SH + MAP_CELLS - 1) / MAP_CELLS);

	localparam int SCAN_W = (SEAT_CELLS > 1) ? $clog2(SEAT_CELLS) : 1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE      = 2'd2;

	localparam logic [HEIGHT_W-1:0] MIN_HEIGHT_RESET = 12'd144;
	localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_RESET = 12'd368;
	localparam logic [HEIGHT_W-1:0] NOISE_RESET      = 12'd48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_STORE,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic                en;
		logic [IDX_W-1:0]    idx;
		logic [HEIGHT_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic en;
		logic first;
	} scan_ctl_t;

endpackage

@@ rtl/core/gwsd_ring_mod.sv @@
// Reciprocal multiply unit that reduces a biased position modulo the map size.
module gwsd_ring_mod (
	input  logic                              clk,
	input  logic                              load,
	input  logic                              step,
	input  logic [gwsd_pkg::BIAS_W-1:0]       value,
	output logic [gwsd_pkg::IDX_W-1:0]        idx
);

	logic [gwsd_pkg::BIAS_W-1:0]                   val_q;
	logic [gwsd_pkg::QUO_W-1:0]                    quo_q;
	logic [gwsd_pkg::BIAS_W+gwsd_pkg::RECIP_W-1:0] product;
	logic [gwsd_pkg::QUO_W-1:0]                    quo_cells;

	always_comb begin
		product   = val_q * gwsd_pkg::RECIP;
		quo_cells = quo_q * gwsd_pkg::QUO_W'(gwsd_pkg::MAP_CELLS);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= value;
		end
		if (step) begin
			quo_q <= product[gwsd_pkg::RECIP_SH +: gwsd_pkg::QUO_W];
		end
	end

	// The remainder is below the map size, so its low bits alone are exact.
	assign idx = val_q[gwsd_pkg::IDX_W-1:0] - quo_cells[gwsd_pkg::IDX_W-1:0];

endmodule

@@ rtl/core/gwsd_height_mem.sv @@
// Height map memory with one write port, one registered read port and reset valid bits.
module gwsd_height_mem (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gwsd_pkg::mem_wr_t                  wr,
	input  logic                               rd_en,
	input  logic [gwsd_pkg::IDX_W-1:0]         rd_idx,
	output logic [gwsd_pkg::HEIGHT_W-1:0]      rd_data
);

	logic [gwsd_pkg::HEIGHT_W-1:0] mem [gwsd_pkg::MAP_CELLS];
	logic [gwsd_pkg::MAP_CELLS-1:0] valid_q;
	logic [gwsd_pkg::HEIGHT_W-1:0] rd_data_s1;
	logic                          rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_idx];
			end
		end
	end

	assign rd_data = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

@@ rtl/core/gwsd_window_eval.sv @@
// Running minimum and maximum over the seat window and the safe zone decision.
module gwsd_window_eval (
	input  logic                               clk,
	input  gwsd_pkg::scan_ctl_t                scan,
	input  logic [gwsd_pkg::HEIGHT_W-1:0]      height,
	input  logic [gwsd_pkg::HEIGHT_W-1:0]      min_height_limit,
	input  logic [gwsd_pkg::HEIGHT_W-1:0]      max_height_limit,
	input  logic [gwsd_pkg::HEIGHT_W-1:0]      surface_noise_limit,
	output logic                               safe_now
);

	logic [gwsd_pkg::HEIGHT_W-1:0] lo_q;
	logic [gwsd_pkg::HEIGHT_W-1:0] hi_q;
	logic [gwsd_pkg::HEIGHT_W-1:0] spread;
	logic [gwsd_pkg::SUM_W-1:0]    sum;

	always_ff @(posedge clk) begin
		if (scan.en) begin
			if (scan.first || height < lo_q) begin
				lo_q <= height;
			end
			if (scan.first || height > hi_q) begin
				hi_q <= height;
			end
		end
	end

	always_comb begin
		spread   = hi_q - lo_q;
		sum      = {1'b0, hi_q} + {1'b0, lo_q};
		safe_now = (spread < surface_noise_limit) &&
			(sum < {max_height_limit, 1'b0}) &&
			(sum > {min_height_limit, 1'b0});
	end

endmodule

@@ rtl/core/ground_window_safe_detector.sv @@
// Top level of the ground window safe detector: sequencer, registers and handshakes.
// A still request goes straight to evaluation; a moving one passes through the steps below first.
// No new request is taken until the last one is evaluated; a stalled output holds the evaluation back.
// A moving request takes the remainder step, the map write and 9 window reads on one memory port.
// Reset clears the map valid bits, position and flag and loads the default limits at once; no clearing pass.
module ground_window_safe_detector (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [gwsd_pkg::POS_W-1:0]     position,
	input  logic [gwsd_pkg::HEIGHT_W-1:0]         right_distance,
	input  logic [gwsd_pkg::HEIGHT_W-1:0]         left_distance,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  safe,
	output logic                                  safe_changed,
	output logic                                  stop_request,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [gwsd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gwsd_pkg::HEIGHT_W-1:0]         cfg_data
);

	gwsd_pkg::state_t state_q, state_next;

	logic signed [gwsd_pkg::POS_W-1:0] prev_q;
	logic [gwsd_pkg::HEIGHT_W-1:0]     dist_q;
	logic                              moved_q;
	logic                              safe_q;
	logic [gwsd_pkg::SCAN_W-1:0]       k_q;
	logic [gwsd_pkg::IDX_W-1:0]        rd_ptr_q;
	gwsd_pkg::scan_ctl_t               scan_s1;

	logic [gwsd_pkg::HEIGHT_W-1:0] min_limit_q;
	logic [gwsd_pkg::HEIGHT_W-1:0] max_limit_q;
	logic [gwsd_pkg::HEIGHT_W-1:0] noise_limit_q;

	logic out_valid_q, safe_out_q, changed_out_q, stop_out_q;

	logic in_accept, moving, go_right;
	logic mod_step, rd_en, eval_fire, ready;
	logic [gwsd_pkg::BIAS_W-1:0] pos_ext, prev_ext, store_val, win_val;
	logic [gwsd_pkg::IDX_W-1:0]  store_idx, win_idx;
	logic [gwsd_pkg::HEIGHT_W-1:0] rd_data;
	gwsd_pkg::mem_wr_t mem_wr;
	logic safe_now, safe_next;

	assign in_accept = in_valid && !in_stall;
	assign moving    = (position != prev_q);
	assign go_right  = (position > prev_q);

	always_comb begin
		pos_ext   = {{(gwsd_pkg::BIAS_W - gwsd_pkg::POS_W){position[gwsd_pkg::POS_W-1]}},
			position};
		prev_ext  = {{(gwsd_pkg::BIAS_W - gwsd_pkg::POS_W){prev_q[gwsd_pkg::POS_W-1]}},
			prev_q};
		store_val = go_right
			? pos_ext + gwsd_pkg::BIAS_W'(gwsd_pkg::BIAS_OFFSET + gwsd_pkg::MAP_CELLS / 2)
			: pos_ext + gwsd_pkg::BIAS_W'(gwsd_pkg::BIAS_OFFSET - gwsd_pkg::MAP_CELLS / 2);
		win_val   = prev_ext +
			gwsd_pkg::BIAS_W'(gwsd_pkg::BIAS_OFFSET - gwsd_pkg::SEAT_CELLS / 2);
	end

	gwsd_ring_mod u_store_mod (
		.clk   (clk),
		.load  (in_accept),
		.step  (mod_step),
		.value (store_val),
		.idx   (store_idx)
	);

	gwsd_ring_mod u_win_mod (
		.clk   (clk),
		.load  (in_accept),
		.step  (mod_step),
		.value (win_val),
		.idx   (win_idx)
	);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			gwsd_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_next = moving ? gwsd_pkg::ST_MOD : gwsd_pkg::ST_EVAL;
				end
			end
			gwsd_pkg::ST_MOD: state_next = gwsd_pkg::ST_STORE;
			gwsd_pkg::ST_STORE: state_next = gwsd_pkg::ST_SCAN;
			gwsd_pkg::ST_SCAN: begin
				if (k_q == gwsd_pkg::SCAN_W'(gwsd_pkg::SEAT_CELLS - 1)) begin
					state_next = gwsd_pkg::ST_DRAIN;
				end
			end
			gwsd_pkg::ST_DRAIN: state_next = gwsd_pkg::ST_EVAL;
			gwsd_pkg::ST_EVAL: begin
				if (ready) begin
					state_next = gwsd_pkg::ST_IDLE;
				end
			end
			default: state_next = gwsd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != gwsd_pkg::ST_IDLE);
		mod_step  = (state_q == gwsd_pkg::ST_MOD);
		rd_en     = (state_q == gwsd_pkg::ST_SCAN);
		ready     = !out_valid_q || !out_stall;
		eval_fire = (state_q == gwsd_pkg::ST_EVAL) && ready;
		mem_wr.en   = (state_q == gwsd_pkg::ST_STORE);
		mem_wr.idx  = store_idx;
		mem_wr.data = dist_q;
	end

	gwsd_height_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mem_wr),
		.rd_en   (rd_en),
		.rd_idx  (rd_ptr_q),
		.rd_data (rd_data)
	);

	gwsd_window_eval u_eval (
		.clk                 (clk),
		.scan                (scan_s1),
		.height              (rd_data),
		.min_height_limit    (min_limit_q),
		.max_height_limit    (max_limit_q),
		.surface_noise_limit (noise_limit_q),
		.safe_now            (safe_now)
	);

	assign safe_next = moved_q ? safe_now : safe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= gwsd_pkg::ST_IDLE;
			prev_q        <= '0;
			safe_q        <= 1'b0;
			moved_q       <= 1'b0;
			k_q           <= '0;
			scan_s1       <= '0;
			out_valid_q   <= 1'b0;
			min_limit_q   <= gwsd_pkg::MIN_HEIGHT_RESET;
			max_limit_q   <= gwsd_pkg::MAX_HEIGHT_RESET;
			noise_limit_q <= gwsd_pkg::NOISE_RESET;
		end else begin
			state_q <= state_next;
			scan_s1.en    <= rd_en;
			scan_s1.first <= rd_en && (k_q == '0);
			if (in_accept) begin
				prev_q  <= position;
				moved_q <= moving;
			end
			if (mem_wr.en) begin
				k_q <= '0;
			end else if (rd_en) begin
				k_q <= k_q + 1'b1;
			end
			if (eval_fire) begin
				safe_q      <= safe_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					gwsd_pkg::REG_MIN_HEIGHT: min_limit_q   <= cfg_data;
					gwsd_pkg::REG_MAX_HEIGHT: max_limit_q   <= cfg_data;
					gwsd_pkg::REG_NOISE:      noise_limit_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			dist_q <= go_right ? right_distance : left_distance;
		end
		if (mem_wr.en) begin
			rd_ptr_q <= win_idx;
		end else if (rd_en) begin
			rd_ptr_q <= (rd_ptr_q == gwsd_pkg::IDX_W'(gwsd_pkg::MAP_CELLS - 1))
				? '0 : rd_ptr_q + 1'b1;
		end
		if (eval_fire) begin
			safe_out_q    <= safe_next;
			changed_out_q <= (safe_next != safe_q);
			stop_out_q    <= (safe_next != safe_q) && safe_next;
		end
	end

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign safe         = safe_out_q;
	assign safe_changed = changed_out_q;
	assign stop_request = stop_out_q;

endmodule

@@ rtl/core/gwsd_checker.sv @@
// Port level checker of the ground window safe detector and its bind statement.
module gwsd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic safe,
	input logic safe_changed,
	input logic stop_request
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(safe) &&
			$stable(safe_changed) && $stable(stop_request))
		else $error("Stalled result changed or vanished.");

	a_stop_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stop_request |-> safe && safe_changed)
		else $error("Stop request without a change to safe.");

	a_change_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && safe_changed |-> stop_request == safe)
		else $error("Stop request does not follow the flipped flag.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("A second request was taken while one is in work.");

endmodule

bind ground_window_safe_detector gwsd_checker u_gwsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.safe         (safe),
	.safe_changed (safe_changed),
	.stop_request (stop_request)
);
